[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and muted during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/gpdtc_pkg.sv]
// ----------------------------------------------------------------------------
// Grid path turn-cost package
// Field widths, configuration codes, defaults and shared flag structs.
// ----------------------------------------------------------------------------
package gpdtc_pkg;

  // Payload field widths.
  localparam int unsigned EDGE_COST_W = 16;
  localparam int unsigned CORNER_W    = 16;
  localparam int unsigned BEST_COST_W = 24;

  // Configuration port.
  localparam int unsigned COLS_CFG_W = 7;
  localparam int unsigned ROWS_CFG_W = 16;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLUMNS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS    = 1'd1;

  localparam logic [COLS_CFG_W-1:0] GRID_COLUMNS_RST = 7'd64;
  localparam logic [ROWS_CFG_W-1:0] GRID_ROWS_RST    = 16'd64;

  // Default sizing.
  localparam int unsigned MAX_COLUMNS_DEF = 64;
  localparam int unsigned COST_BITS_DEF   = 24;

  // Where the current cell sits in the grid.
  typedef struct packed {
    logic row_first;
    logic row_second;
    logic col_first;
    logic col_second;
    logic final_cell;
  } pos_flags_t;

  // Status of a neighbor cell as kept in the row buffer.
  typedef struct packed {
    logic reach;
    logic vertical;
  } nbr_flags_t;

endpackage

[src/gpdtc_if.sv]
// ----------------------------------------------------------------------------
// Grid path turn-cost channels
// Valid/ready channels for the intersection stream and the result stream.
// ----------------------------------------------------------------------------
interface gpdtc_in_if;
  import gpdtc_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [EDGE_COST_W-1:0] up_edge_cost;
  logic                   up_edge_present;
  logic [EDGE_COST_W-1:0] left_edge_cost;
  logic                   left_edge_present;
  logic [CORNER_W-1:0]    corner_cost;

  modport source (
    output valid, up_edge_cost, up_edge_present, left_edge_cost, left_edge_present,
           corner_cost,
    input  ready
  );

  modport sink (
    input  valid, up_edge_cost, up_edge_present, left_edge_cost, left_edge_present,
           corner_cost,
    output ready
  );
endinterface

interface gpdtc_out_if;
  import gpdtc_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [BEST_COST_W-1:0] best_cost;
  logic                   reachable;
  logic                   arrived_vertically;
  logic                   final_cell;

  modport source (
    output valid, best_cost, reachable, arrived_vertically, final_cell,
    input  ready
  );

  modport sink (
    input  valid, best_cost, reachable, arrived_vertically, final_cell,
    output ready
  );
endinterface

[src/gpdtc_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered, enabled read data.
// ----------------------------------------------------------------------------
module gpdtc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/gpdtc_pos.sv]
// ----------------------------------------------------------------------------
// Grid position tracker
// Holds the size registers and the raster position of the next request.
// ----------------------------------------------------------------------------
module gpdtc_pos #(
  parameter int unsigned MaxColumns = gpdtc_pkg::MAX_COLUMNS_DEF,
  parameter int unsigned ColW       = (MaxColumns > 1) ? $clog2(MaxColumns) : 1
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [gpdtc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [gpdtc_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  logic                                advance_i,
  output logic [ColW-1:0]                     col_o,
  output gpdtc_pkg::pos_flags_t               flags_o
);
  import gpdtc_pkg::*;

  localparam int unsigned CntW0 = $clog2(MaxColumns + 1);
  localparam int unsigned CntW  = (CntW0 > COLS_CFG_W) ? CntW0 : COLS_CFG_W;
  localparam int unsigned RowW  = ROWS_CFG_W;

  logic [COLS_CFG_W-1:0] grid_columns_q;
  logic [ROWS_CFG_W-1:0] grid_rows_q;
  logic [ColW-1:0]       col_q, col_d;
  logic [RowW-1:0]       row_q, row_d;

  logic [CntW-1:0]   cols_ext, cols_eff, col_plus1;
  logic [ROWS_CFG_W-1:0] rows_eff;
  logic [RowW:0]     row_plus1;
  logic              last_col, final_cell;

  // Size registers; the user must write them only while idle (not enforced).
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_columns_q <= GRID_COLUMNS_RST;
      grid_rows_q    <= GRID_ROWS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GRID_COLUMNS: grid_columns_q <= cfg_wdata_i[COLS_CFG_W-1:0];
        CFG_GRID_ROWS:    grid_rows_q    <= cfg_wdata_i[ROWS_CFG_W-1:0];
        default:          ;
      endcase
    end
  end

  // Effective sizes: zero acts as one, and columns clamp to the buffer depth.
  always_comb begin
    cols_ext = CntW'(grid_columns_q);
    if (cols_ext == '0) begin
      cols_eff = CntW'(1);
    end else if (cols_ext > CntW'(MaxColumns)) begin
      cols_eff = CntW'(MaxColumns);
    end else begin
      cols_eff = cols_ext;
    end
    rows_eff = (grid_rows_q == '0) ? ROWS_CFG_W'(1) : grid_rows_q;
  end

  // End-of-row and end-of-grid tests for the current position.
  assign col_plus1  = CntW'(col_q) + CntW'(1);
  assign row_plus1  = {1'b0, row_q} + (RowW+1)'(1);
  assign last_col   = (col_plus1 >= cols_eff);
  assign final_cell = last_col && (row_plus1 >= {1'b0, rows_eff});

  // Next position after an accepted request.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (advance_i) begin
      priority if (final_cell) begin
        col_d = '0;
        row_d = '0;
      end else if (last_col) begin
        col_d = '0;
        row_d = row_plus1[RowW-1:0];
      end else begin
        col_d = col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign col_o              = col_q;
  assign flags_o.row_first  = (row_q == '0);
  assign flags_o.row_second = (row_q == RowW'(1));
  assign flags_o.col_first  = (col_q == '0);
  assign flags_o.col_second = (col_q == ColW'(1));
  assign flags_o.final_cell = final_cell;

endmodule

[src/gpdtc_relax.sv]
// ----------------------------------------------------------------------------
// Cell relaxation
// Picks the cheaper of the arrivals from above and from the left, adding
// the neighbor's turn penalty when the path changes axis there.
// ----------------------------------------------------------------------------
module gpdtc_relax #(
  parameter int unsigned CostBits = gpdtc_pkg::COST_BITS_DEF
) (
  input  gpdtc_pkg::pos_flags_t                  flags_i,
  input  logic [gpdtc_pkg::EDGE_COST_W-1:0]      up_edge_cost_i,
  input  logic                                   up_edge_present_i,
  input  logic [gpdtc_pkg::EDGE_COST_W-1:0]      left_edge_cost_i,
  input  logic                                   left_edge_present_i,
  input  logic [CostBits-1:0]                    up_cost_i,
  input  gpdtc_pkg::nbr_flags_t                  up_flags_i,
  input  logic [gpdtc_pkg::CORNER_W-1:0]         up_corner_i,
  input  logic [CostBits-1:0]                    left_cost_i,
  input  gpdtc_pkg::nbr_flags_t                  left_flags_i,
  input  logic [gpdtc_pkg::CORNER_W-1:0]         left_corner_i,
  output logic [CostBits-1:0]                    cost_o,
  output gpdtc_pkg::nbr_flags_t                  flags_o
);
  import gpdtc_pkg::*;

  localparam int unsigned SumW = CostBits + 2;

  logic                up_ok, left_ok;
  logic [CORNER_W-1:0] up_pen, left_pen;
  logic [SumW-1:0]     sum_y_raw, sum_x_raw;
  logic [CostBits-1:0] sum_y, sum_x;

  // A neighbor only counts if its edge exists and a path reaches it.
  assign up_ok   = !flags_i.row_first && up_edge_present_i && up_flags_i.reach;
  assign left_ok = !flags_i.col_first && left_edge_present_i && left_flags_i.reach;

  // Turning at the upper neighbor means it was entered horizontally; the
  // start cell has no direction, so leaving it never adds a penalty.
  assign up_pen = (!(flags_i.row_second && flags_i.col_first) && !up_flags_i.vertical)
                  ? up_corner_i : '0;
  assign left_pen = (!(flags_i.row_first && flags_i.col_second) && left_flags_i.vertical)
                    ? left_corner_i : '0;

  assign sum_y_raw = SumW'(up_cost_i) + SumW'(up_edge_cost_i) + SumW'(up_pen);
  assign sum_x_raw = SumW'(left_cost_i) + SumW'(left_edge_cost_i) + SumW'(left_pen);

  // Saturate at the all-ones cost.
  assign sum_y = (sum_y_raw[SumW-1:CostBits] != '0) ? '1 : sum_y_raw[CostBits-1:0];
  assign sum_x = (sum_x_raw[SumW-1:CostBits] != '0) ? '1 : sum_x_raw[CostBits-1:0];

  // Selection; a tie goes vertical.
  always_comb begin
    cost_o           = '0;
    flags_o.reach    = 1'b0;
    flags_o.vertical = 1'b0;
    priority if (flags_i.row_first && flags_i.col_first) begin
      flags_o.reach = 1'b1;
    end else if (up_ok && left_ok) begin
      flags_o.reach = 1'b1;
      if (sum_x < sum_y) begin
        cost_o = sum_x;
      end else begin
        cost_o           = sum_y;
        flags_o.vertical = 1'b1;
      end
    end else if (up_ok) begin
      flags_o.reach    = 1'b1;
      flags_o.vertical = 1'b1;
      cost_o           = sum_y;
    end else if (left_ok) begin
      flags_o.reach = 1'b1;
      cost_o        = sum_x;
    end
  end

endmodule

[src/grid_path_dp_turn_cost.sv]
// ----------------------------------------------------------------------------
// Grid minimum-cost path with turn penalty
// Streams grid intersections in raster order and returns each cell's best
// monotone path cost from the top-left cell.
// ----------------------------------------------------------------------------
// Usage: in_i carries one intersection per request, row by row and left to
// right: the up and left edge costs with their present flags, and the
// intersection's corner cost. out_o returns one result per request in the
// same order: best cost, reachable, arrived-vertically and a final-cell flag
// on the bottom-right cell, after which the next request starts a new grid.
// The size registers (grid_columns, grid_rows) are written through the
// cfg_we_i/cfg_idx_i/cfg_wdata_i port while no request is in flight.
// The accept edge loads the input stage and the row-buffer read; the result
// register is loaded when the cell leaves the input stage. Throughput is
// one request per cycle while out_o is not stalled, set by the single
// row-buffer read per cell and the left-neighbor result fed back from the
// previous cycle. Reset returns the position to the top-left cell and the
// sizes to 64 by 64; the row buffer is not cleared and needs no pass.
// When the receiver stalls, the result register holds and one more request
// is taken into the input stage; then in_i.ready drops until out_o moves.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module grid_path_dp_turn_cost #(
  parameter int unsigned MAX_COLUMNS = gpdtc_pkg::MAX_COLUMNS_DEF,
  parameter int unsigned COST_BITS   = gpdtc_pkg::COST_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [gpdtc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [gpdtc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  gpdtc_in_if.sink                         in_i,
  gpdtc_out_if.source                      out_o
);
  import gpdtc_pkg::*;

  localparam int unsigned ColW   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int unsigned EntryW = COST_BITS + 2 + CORNER_W;

  // Handshake control.
  logic s1_valid_q, out_valid_q;
  logic s1_adv, accept;

  // Position of the next request.
  logic [ColW-1:0] pos_col;
  pos_flags_t      pos_flags;

  // Input stage.
  logic [ColW-1:0]        s1_col_q;
  pos_flags_t             s1_flags_q;
  logic [EDGE_COST_W-1:0] s1_up_edge_cost_q;
  logic                   s1_up_edge_present_q;
  logic [EDGE_COST_W-1:0] s1_left_edge_cost_q;
  logic                   s1_left_edge_present_q;
  logic [CORNER_W-1:0]    s1_corner_q;
  logic                   fwd_q;

  // Previous result, which is the left neighbor of the cell in the stage.
  logic [COST_BITS-1:0] left_cost_q;
  nbr_flags_t           left_flags_q;
  logic [CORNER_W-1:0]  left_corner_q;

  // Row buffer.
  logic [EntryW-1:0]    ram_wdata, ram_rdata;
  logic [COST_BITS-1:0] up_cost;
  nbr_flags_t           up_flags;
  logic [CORNER_W-1:0]  up_corner;

  // Relaxation result.
  logic [COST_BITS-1:0] res_cost;
  nbr_flags_t           res_flags;

  // Result register.
  logic [BEST_COST_W-1:0] out_cost_q;
  logic                   out_reach_q;
  logic                   out_vert_q;
  logic                   out_final_q;

  // The stage moves on when the result register is empty or being read.
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign accept     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  gpdtc_pos #(
    .MaxColumns (MAX_COLUMNS),
    .ColW       (ColW)
  ) u_pos (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .advance_i   (accept),
    .col_o       (pos_col),
    .flags_o     (pos_flags)
  );

  // Input stage load. When the cell ahead writes the same column on the
  // accept edge, the read returns stale data and the previous result is
  // used instead.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_col_q               <= pos_col;
      s1_flags_q             <= pos_flags;
      s1_up_edge_cost_q      <= in_i.up_edge_cost;
      s1_up_edge_present_q   <= in_i.up_edge_present;
      s1_left_edge_cost_q    <= in_i.left_edge_cost;
      s1_left_edge_present_q <= in_i.left_edge_present;
      s1_corner_q            <= in_i.corner_cost;
      fwd_q                  <= s1_adv && (s1_col_q == pos_col);
    end
  end

  // Row buffer: read at accept, written when the cell leaves the stage.
  assign ram_wdata = {res_cost, res_flags, s1_corner_q};

  gpdtc_ram #(
    .Width (EntryW),
    .Depth (MAX_COLUMNS),
    .AddrW (ColW)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_col_q),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (pos_col),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    if (fwd_q) begin
      up_cost   = left_cost_q;
      up_flags  = left_flags_q;
      up_corner = left_corner_q;
    end else begin
      up_cost   = ram_rdata[EntryW-1 -: COST_BITS];
      up_flags  = ram_rdata[CORNER_W +: 2];
      up_corner = ram_rdata[CORNER_W-1:0];
    end
  end

  gpdtc_relax #(
    .CostBits (COST_BITS)
  ) u_relax (
    .flags_i             (s1_flags_q),
    .up_edge_cost_i      (s1_up_edge_cost_q),
    .up_edge_present_i   (s1_up_edge_present_q),
    .left_edge_cost_i    (s1_left_edge_cost_q),
    .left_edge_present_i (s1_left_edge_present_q),
    .up_cost_i           (up_cost),
    .up_flags_i          (up_flags),
    .up_corner_i         (up_corner),
    .left_cost_i         (left_cost_q),
    .left_flags_i        (left_flags_q),
    .left_corner_i       (left_corner_q),
    .cost_o              (res_cost),
    .flags_o             (res_flags)
  );

  // Left-neighbor feedback and result register.
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      left_cost_q   <= res_cost;
      left_flags_q  <= res_flags;
      left_corner_q <= s1_corner_q;
      out_cost_q    <= BEST_COST_W'(res_cost);
      out_reach_q   <= res_flags.reach;
      out_vert_q    <= res_flags.vertical;
      out_final_q   <= s1_flags_q.final_cell;
    end
  end

  assign out_o.valid              = out_valid_q;
  assign out_o.best_cost          = out_cost_q;
  assign out_o.reachable          = out_reach_q;
  assign out_o.arrived_vertically = out_vert_q;
  assign out_o.final_cell         = out_final_q;

  // Assertions.
  `ASSERT_IMPLIES(a_full_blocks_input, s1_valid_q && out_valid_q && !out_o.ready, !in_i.ready, "input taken while both stages are full")
  `ASSERT_NEXT(a_start_cell_zero, s1_adv && s1_flags_q.row_first && s1_flags_q.col_first, out_o.reachable && !out_o.arrived_vertically && (out_o.best_cost == '0), "start cell result is not zero cost")
  `ASSERT_IMPLIES(a_unreach_zero, out_valid_q && !out_o.reachable, (out_o.best_cost == '0) && !out_o.arrived_vertically, "unreachable cell carries a cost or direction")
  `ASSERT_NEXT(a_stage_to_result, s1_adv, out_valid_q, "stage moved without loading the result")

endmodule

[sim/tb_grid_path_dp_turn_cost.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Grid path turn-cost testbench
// Streams grid intersections into the block while the sender idles in random
// bursts and the receiver stalls on its own patterns. A local model of the
// row buffer predicts every cell's best cost, reachability, arrival direction
// and final-cell flag, and each result is checked in order against it.
// ----------------------------------------------------------------------------
module tb_grid_path_dp_turn_cost;
  import gpdtc_pkg::*;

  localparam int unsigned     NUM_COLS     = MAX_COLUMNS_DEF;
  localparam longint unsigned COST_SAT     = (64'd1 << COST_BITS_DEF) - 64'd1;
  localparam int unsigned     RANDOM_ITEMS = 300;
  localparam int unsigned     MAX_REPORTS  = 10;
  localparam int unsigned     TAIL_CYCLES  = 8;
  localparam longint unsigned TIMEOUT_NS   = 64'd8_000_000;

  typedef struct packed {
    logic [EDGE_COST_W-1:0] up_cost;
    logic                   up_present;
    logic [EDGE_COST_W-1:0] left_cost;
    logic                   left_present;
    logic [CORNER_W-1:0]    corner;
  } cell_t;

  typedef struct packed {
    logic [BEST_COST_W-1:0] best_cost;
    logic                   reachable;
    logic                   arrived_vertically;
    logic                   final_cell;
  } cell_result_t;

  typedef enum int unsigned {COST_TINY, COST_FULL, COST_EXTREME} cost_mix_e;
  typedef enum int unsigned {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_SPARSE} rx_mode_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  gpdtc_in_if  in_bus ();
  gpdtc_out_if out_bus ();

  grid_path_dp_turn_cost uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_bus),
    .out_o       (out_bus)
  );

  // Local copy of the row buffer, the position and the size registers.
  logic [COST_BITS_DEF-1:0] line_cost     [NUM_COLS];
  logic                     line_reach    [NUM_COLS];
  logic                     line_vertical [NUM_COLS];
  logic [CORNER_W-1:0]      line_corner   [NUM_COLS];
  int unsigned              cur_col;
  int unsigned              cur_row;
  logic [COLS_CFG_W-1:0]    cols_reg;
  logic [ROWS_CFG_W-1:0]    rows_reg;

  cell_result_t expected_cells[$];
  int unsigned  error_count;
  int unsigned  burst_left;

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Computes the result of one accepted cell and advances the local state.
  function automatic cell_result_t predict_cell(input cell_t c);
    int unsigned     ncols, nrows, col, row;
    longint unsigned via_up, via_left, best;
    logic            up_ok, left_ok, reach, vert, last_col;
    cell_result_t    r;
    ncols = (cols_reg == 0) ? 1 : ((cols_reg > NUM_COLS) ? NUM_COLS : cols_reg);
    nrows = (rows_reg == 0) ? 1 : rows_reg;
    col = (cur_col >= NUM_COLS) ? NUM_COLS - 1 : cur_col;
    row = cur_row;
    best = 0;
    reach = 1'b0;
    vert = 1'b0;
    via_up = 0;
    via_left = 0;
    if (row == 0 && col == 0) begin
      // The start cell costs nothing and has no direction.
      reach = 1'b1;
    end else begin
      up_ok = (row > 0) && c.up_present && line_reach[col];
      left_ok = 1'b0;
      if (col > 0) begin
        left_ok = c.left_present && line_reach[col-1];
      end
      // A turn at the neighbor adds its corner cost, except at the start cell.
      if (up_ok) begin
        via_up = line_cost[col] + c.up_cost;
        if (!(row == 1 && col == 0) && !line_vertical[col]) begin
          via_up += line_corner[col];
        end
        if (via_up > COST_SAT) via_up = COST_SAT;
      end
      if (left_ok) begin
        via_left = line_cost[col-1] + c.left_cost;
        if (!(row == 0 && col == 1) && line_vertical[col-1]) begin
          via_left += line_corner[col-1];
        end
        if (via_left > COST_SAT) via_left = COST_SAT;
      end
      // A tie goes to the arrival from above.
      if (up_ok && left_ok) begin
        reach = 1'b1;
        if (via_left < via_up) begin
          best = via_left;
        end else begin
          best = via_up;
          vert = 1'b1;
        end
      end else if (up_ok) begin
        reach = 1'b1;
        best = via_up;
        vert = 1'b1;
      end else if (left_ok) begin
        reach = 1'b1;
        best = via_left;
      end
    end

    line_cost[col] = best[COST_BITS_DEF-1:0];
    line_reach[col] = reach;
    line_vertical[col] = vert;
    line_corner[col] = c.corner;

    last_col = (col + 1 >= ncols);
    r.best_cost = best[BEST_COST_W-1:0];
    r.reachable = reach;
    r.arrived_vertically = vert;
    r.final_cell = last_col && (row + 1 >= nrows);

    if (r.final_cell) begin
      cur_col = 0;
      cur_row = 0;
    end else if (last_col) begin
      cur_col = 0;
      cur_row = (row + 1) & 32'hFFFF;
    end else begin
      cur_col = col + 1;
    end
    return r;
  endfunction

  function automatic cell_t make_cell(input logic [EDGE_COST_W-1:0] up_cost,
                                      input logic up_present,
                                      input logic [EDGE_COST_W-1:0] left_cost,
                                      input logic left_present,
                                      input logic [CORNER_W-1:0] corner);
    cell_t c;
    c.up_cost = up_cost;
    c.up_present = up_present;
    c.left_cost = left_cost;
    c.left_present = left_present;
    c.corner = corner;
    return c;
  endfunction

  function automatic logic [EDGE_COST_W-1:0] random_cost(input cost_mix_e mix);
    logic [EDGE_COST_W-1:0] v;
    case (mix)
      COST_TINY: begin
        v = $urandom_range(0, 3);
      end
      COST_EXTREME: begin
        if ($urandom_range(0, 1) == 0) v = 16'hFFFF - $urandom_range(0, 2);
        else v = $urandom_range(0, 2);
      end
      default: begin
        v = $urandom;
      end
    endcase
    return v;
  endfunction

  function automatic cell_t random_cell(input cost_mix_e mix);
    return make_cell(random_cost(mix), $urandom_range(0, 99) < 85,
                     random_cost(mix), $urandom_range(0, 99) < 85,
                     random_cost(mix));
  endfunction

  // Sends one request, records its expected result and idles between bursts.
  task automatic send_cell(input cell_t c, output logic last_cell);
    cell_result_t r;
    int unsigned  gap;
    in_bus.valid <= 1'b1;
    in_bus.up_edge_cost <= c.up_cost;
    in_bus.up_edge_present <= c.up_present;
    in_bus.left_edge_cost <= c.left_cost;
    in_bus.left_edge_present <= c.left_present;
    in_bus.corner_cost <= c.corner;
    do @(posedge clk_i); while (!in_bus.ready);
    r = predict_cell(c);
    expected_cells = {expected_cells, r};
    last_cell = r.final_cell;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = $urandom_range(0, 99);
      if (gap < 30) gap = 0;
      else if (gap < 95) gap = $urandom_range(1, 6);
      else gap = $urandom_range(10, 20);
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Sends random cells until the grid ends or the count runs out.
  task automatic run_random_cells(input int unsigned max_cells, input cost_mix_e mix,
                                  output int unsigned sent);
    logic last_cell;
    sent = 0;
    last_cell = 1'b0;
    while (!last_cell && sent < max_cells) begin
      send_cell(random_cell(mix), last_cell);
      sent++;
    end
  endtask

  // Holds off the sender until every expected result has come back.
  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    do @(posedge clk_i); while (expected_cells.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CFG_GRID_COLUMNS) cols_reg = data[COLS_CFG_W-1:0];
    else rows_reg = data[ROWS_CFG_W-1:0];
    @(posedge clk_i);
  endtask

  task automatic set_grid(input logic [CFG_DATA_W-1:0] cols,
                          input logic [CFG_DATA_W-1:0] rows);
    wait_drained();
    write_reg(CFG_GRID_COLUMNS, cols);
    write_reg(CFG_GRID_ROWS, rows);
  endtask

  // The reset size is 64 by 64, so one full row writes every row-buffer entry.
  // Shrinking both sizes on row 1 then makes the next cell end the grid.
  task automatic test_full_width_row();
    int unsigned sent;
    run_random_cells(NUM_COLS, COST_FULL, sent);
    wait_drained();
    write_reg(CFG_GRID_COLUMNS, 16'd1);
    write_reg(CFG_GRID_ROWS, 16'd1);
    run_random_cells(NUM_COLS, COST_FULL, sent);
  endtask

  // A hand-built 3 by 3 grid: ignored border edges, turn penalties, blocked
  // edges, an unreachable cell and predecessor, and a tie at the last cell.
  // Then zero sizes, which act as a single-cell grid.
  task automatic test_directed_grid();
    logic last_cell;
    set_grid(16'd3, 16'd3);
    send_cell(make_cell(16'hFFFF, 1'b1, 16'hFFFF, 1'b1, 16'd5), last_cell);
    send_cell(make_cell(16'hFFFF, 1'b1, 16'd10, 1'b1, 16'd7), last_cell);
    send_cell(make_cell(16'd0, 1'b1, 16'd0, 1'b0, 16'd0), last_cell);
    send_cell(make_cell(16'd20, 1'b1, 16'hFFFF, 1'b1, 16'd3), last_cell);
    send_cell(make_cell(16'd5, 1'b1, 16'd10, 1'b1, 16'd0), last_cell);
    send_cell(make_cell(16'd1, 1'b1, 16'd1, 1'b1, 16'd0), last_cell);
    send_cell(make_cell(16'd0, 1'b0, 16'hFFFF, 1'b1, 16'hFFFF), last_cell);
    send_cell(make_cell(16'd0, 1'b1, 16'd0, 1'b1, 16'd0), last_cell);
    send_cell(make_cell(16'd0, 1'b1, 16'd1, 1'b1, 16'hFFFF), last_cell);
    set_grid(16'd0, 16'd0);
    send_cell(make_cell(16'd0, 1'b0, 16'd0, 1'b0, 16'd0), last_cell);
    send_cell(make_cell(16'hFFFF, 1'b1, 16'hFFFF, 1'b1, 16'hFFFF), last_cell);
  endtask

  // Column clamping above the maximum, the largest row count, and positions
  // left beyond a size that shrank in mid-grid.
  task automatic test_size_extremes();
    int unsigned sent;
    set_grid(16'd127, 16'd1);
    run_random_cells(NUM_COLS, COST_FULL, sent);
    set_grid(16'd2, 16'd65535);
    run_random_cells(7, COST_FULL, sent);
    wait_drained();
    write_reg(CFG_GRID_ROWS, 16'd2);
    run_random_cells(NUM_COLS, COST_FULL, sent);
    set_grid(16'd8, 16'd4);
    run_random_cells(6, COST_TINY, sent);
    wait_drained();
    write_reg(CFG_GRID_COLUMNS, 16'd4);
    run_random_cells(NUM_COLS, COST_TINY, sent);
    // Widen again for a fresh grid; every entry has been written by now.
    wait_drained();
    write_reg(CFG_GRID_COLUMNS, 16'd6);
    run_random_cells(NUM_COLS, COST_FULL, sent);
  endtask

  // A single column of maximum up edges runs the cost into saturation.
  task automatic test_saturation();
    logic        last_cell;
    int unsigned n;
    set_grid(16'd1, 16'd260);
    for (n = 0; n < 260; n++) begin
      send_cell(make_cell(16'hFFFF, 1'b1, random_cost(COST_FULL), 1'b1, 16'hFFFF),
                last_cell);
    end
  endtask

  // Random grid sizes, mostly whole grids with random content, some cut short.
  task automatic test_random_grids();
    int unsigned           done_cells, sent, pick, cols, rows, max_cells;
    logic [CFG_DATA_W-1:0] cols_data;
    cost_mix_e             mix;
    done_cells = 0;
    while (done_cells < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) cols = $urandom_range(1, 8);
      else if (pick < 75) cols = $urandom_range(9, NUM_COLS - 1);
      else if (pick < 85) cols = NUM_COLS;
      else if (pick < 92) cols = 1;
      else if (pick < 96) cols = 0;
      else cols = $urandom_range(NUM_COLS + 1, 127);
      pick = $urandom_range(0, 99);
      if (cols > 8) rows = $urandom_range(1, 2);
      else if (pick < 90) rows = $urandom_range(1, 6);
      else if (pick < 95) rows = 0;
      else rows = $urandom_range(7, 12);
      // Upper data bits beyond the column field are sometimes set.
      cols_data = cols;
      if ($urandom_range(0, 3) == 0) cols_data |= $urandom & 16'hFF80;
      pick = $urandom_range(0, 99);
      mix = (pick < 40) ? COST_TINY : ((pick < 80) ? COST_FULL : COST_EXTREME);
      max_cells = ($urandom_range(0, 99) < 80) ? 4096 : $urandom_range(1, 20);

      wait_drained();
      pick = $urandom_range(0, 99);
      if (done_cells == 0 || pick < 70) begin
        write_reg(CFG_GRID_COLUMNS, cols_data);
        write_reg(CFG_GRID_ROWS, rows);
      end else if (pick < 85) begin
        write_reg(CFG_GRID_COLUMNS, cols_data);
      end else begin
        write_reg(CFG_GRID_ROWS, rows);
      end
      run_random_cells(max_cells, mix, sent);
      done_cells += sent;
    end
  endtask

  // Receiver ready: changes between several stall styles every so often.
  initial begin
    rx_mode_e    mode;
    int unsigned mode_left;
    int unsigned phase;
    logic [7:0]  mask;
    mode = RX_ALWAYS;
    mode_left = 0;
    phase = 0;
    mask = 8'hFF;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (mode_left == 0) begin
        mode = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
        mask = $urandom;
      end
      mode_left--;
      phase = (phase + 1) % 8;
      case (mode)
        RX_ALWAYS:  out_bus.ready <= 1'b1;
        RX_RANDOM:  out_bus.ready <= ($urandom_range(0, 1) == 1);
        RX_PATTERN: out_bus.ready <= mask[phase];
        default:    out_bus.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Result checker: every accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    cell_result_t got, want;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      got.best_cost = out_bus.best_cost;
      got.reachable = out_bus.reachable;
      got.arrived_vertically = out_bus.arrived_vertically;
      got.final_cell = out_bus.final_cell;
      if (expected_cells.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS) begin
          $display("%0t: result with no request waiting: cost %0d reach %b vert %b final %b",
                   $time, got.best_cost, got.reachable, got.arrived_vertically,
                   got.final_cell);
        end
      end else begin
        want = expected_cells.pop_front();
        if (got.best_cost !== want.best_cost || got.reachable !== want.reachable ||
            got.arrived_vertically !== want.arrived_vertically ||
            got.final_cell !== want.final_cell) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("%0t: expected cost %0d reach %b vert %b final %b,", $time,
                     want.best_cost, want.reachable, want.arrived_vertically,
                     want.final_cell, " got cost %0d reach %b vert %b final %b",
                     got.best_cost, got.reachable, got.arrived_vertically,
                     got.final_cell);
          end
        end
      end
    end
  end

  // Main sequence.
  initial begin
    int unsigned n;
    error_count = 0;
    burst_left = 0;
    cur_col = 0;
    cur_row = 0;
    cols_reg = GRID_COLUMNS_RST;
    rows_reg = GRID_ROWS_RST;
    for (n = 0; n < NUM_COLS; n++) begin
      line_cost[n] = '0;
      line_reach[n] = 1'b0;
      line_vertical[n] = 1'b0;
      line_corner[n] = '0;
    end
    rst_ni <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= CFG_GRID_COLUMNS;
    cfg_wdata <= '0;
    in_bus.valid <= 1'b0;
    in_bus.up_edge_cost <= '0;
    in_bus.up_edge_present <= 1'b0;
    in_bus.left_edge_cost <= '0;
    in_bus.left_edge_present <= 1'b0;
    in_bus.corner_cost <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_full_width_row();
    test_directed_grid();
    test_size_extremes();
    test_saturation();
    test_random_grids();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #(TIMEOUT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/gpdtc_pkg.sv
src/gpdtc_if.sv
src/gpdtc_ram.sv
src/gpdtc_pos.sv
src/gpdtc_relax.sv
src/grid_path_dp_turn_cost.sv
sim/tb_grid_path_dp_turn_cost.sv
